// File: rtl/tpts_pkg.sv
`timescale 1ns / 1ps

package tpts_pkg;

    localparam int TASKS_PER_CONTEXT = 8;
    localparam int SLOTS = 2 * TASKS_PER_CONTEXT;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int IDX_W = (TASKS_PER_CONTEXT > 1) ? $clog2(TASKS_PER_CONTEXT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASKS_PER_CONTEXT - 1);
    localparam logic [7:0] AGE_MAX = 8'hFF;

    localparam logic MODE_ADD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef enum logic [1:0] {
        KIND_STEP = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] pri;
        logic [7:0] age;
    } key_t;

    function automatic logic [SLOT_W-1:0] slot_of(input logic ctx, input logic [IDX_W-1:0] idx);
        logic [SLOT_W-1:0] base;
        base = ctx ? SLOT_W'(TASKS_PER_CONTEXT) : '0;
        return base + SLOT_W'(idx);
    endfunction

endpackage

// File: rtl/tpts_cmp.sv
`timescale 1ns / 1ps

module tpts_cmp (
    input  logic              cand_valid,
    input  tpts_pkg::key_t    cand,
    input  logic              best_found,
    input  tpts_pkg::key_t    best,
    output logic              take
);

    // An older task wins a priority tie; an equal key keeps the earlier slot.
    assign take = cand_valid &&
                  (!best_found ||
                   (cand.pri > best.pri) ||
                   ((cand.pri == best.pri) && (cand.age > best.age)));

endmodule

// File: rtl/two_context_priority_task_scheduler.sv
`timescale 1ns / 1ps

// Two contexts of task slots served highest priority first, oldest task on a tie. An add word
// is accepted in the idle state, then placed and its report loaded in the add state. A tick word
// is accepted in the idle state, then walks all slots of both contexts through one shared
// priority comparator, one slot per cycle, for 2*TASKS_PER_CONTEXT slots (16 at the
// default size), then through one step state for each context, in which the step report of
// that context is loaded if it holds a task. The input is ready only when no word is in
// progress; a report may still wait in the output register meanwhile, and a stall on the
// output holds the sequencer in the add and step states while it has a report to load.
module two_context_priority_task_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic        context_req,
    input  logic [15:0] task_value,
    input  logic [7:0]  task_priority,
    input  logic [7:0]  task_steps,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic        which_context,
    output logic [15:0] out_value,
    output logic [7:0]  out_priority,
    output logic [7:0]  step_number,
    output logic [7:0]  total_steps,
    output logic        finished,
    output logic [31:0] square,
    output logic        last
);

    localparam int SLOTS = tpts_pkg::SLOTS;
    localparam int TASKS = tpts_pkg::TASKS_PER_CONTEXT;
    localparam int SLOT_W = tpts_pkg::SLOT_W;
    localparam int IDX_W = tpts_pkg::IDX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_STEP0,
        S_STEP1
    } state_t;

    state_t state_reg;

    logic              valid_reg [SLOTS];
    logic [15:0]       value_reg [SLOTS];
    logic [7:0]        pri_reg   [SLOTS];
    logic [7:0]        total_reg [SLOTS];
    logic [7:0]        done_reg  [SLOTS];
    logic [7:0]        age_reg   [SLOTS];

    logic              it_ctx_reg;
    logic [15:0]       it_value_reg;
    logic [7:0]        it_pri_reg;
    logic [7:0]        it_steps_reg;

    logic              scan_ctx_reg;
    logic [IDX_W-1:0]  scan_idx_reg;
    logic              best_found_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    tpts_pkg::key_t    best_key_reg;
    logic              found0_reg;
    logic [IDX_W-1:0]  slot0_reg;
    logic              found1_reg;
    logic [IDX_W-1:0]  slot1_reg;

    logic              out_valid_reg;
    tpts_pkg::kind_t   kind_reg;
    logic              ctx_out_reg;
    logic [15:0]       value_out_reg;
    logic [7:0]        pri_out_reg;
    logic [7:0]        stepn_out_reg;
    logic [7:0]        total_out_reg;
    logic              fin_out_reg;
    logic [31:0]       square_out_reg;
    logic              last_out_reg;

    logic              can_load;
    logic              in_go;
    logic [SLOT_W-1:0] rd_slot;
    tpts_pkg::key_t    cand_key;
    logic              take;
    logic              nb_found;
    logic [IDX_W-1:0]  nb_idx;
    tpts_pkg::key_t    nb_key;
    logic [7:0]        done_next;
    logic              fin_next;
    logic [31:0]       square_next;
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;
    logic [SLOT_W-1:0] free_slot;
    logic              add_go;
    logic              step_go;
    logic              out_load;

    assign can_load = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign in_go = in_valid && in_ready;

    always_comb
    begin
        case (state_reg)
            S_STEP0: rd_slot = tpts_pkg::slot_of(1'b0, slot0_reg);
            S_STEP1: rd_slot = tpts_pkg::slot_of(1'b1, slot1_reg);
            default: rd_slot = tpts_pkg::slot_of(scan_ctx_reg, scan_idx_reg);
        endcase
    end

    assign cand_key.pri = pri_reg[rd_slot];
    assign cand_key.age = age_reg[rd_slot];

    tpts_cmp u_cmp (
        .cand_valid (valid_reg[rd_slot]),
        .cand       (cand_key),
        .best_found (best_found_reg),
        .best       (best_key_reg),
        .take       (take)
    );

    assign nb_found = best_found_reg || take;
    assign nb_idx = take ? scan_idx_reg : best_idx_reg;
    assign nb_key = take ? cand_key : best_key_reg;

    assign done_next = done_reg[rd_slot] + 8'd1;
    assign fin_next = (done_next >= total_reg[rd_slot]);
    assign square_next = 32'(value_reg[rd_slot]) * 32'(value_reg[rd_slot]);

    always_comb
    begin
        free_found = 1'b0;
        free_idx = '0;
        for (int i = TASKS - 1; i >= 0; i--)
        begin
            if (!valid_reg[tpts_pkg::slot_of(it_ctx_reg, IDX_W'(i))])
            begin
                free_found = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    assign free_slot = tpts_pkg::slot_of(it_ctx_reg, free_idx);
    assign add_go = (state_reg == S_ADD) && can_load && free_found;
    assign step_go = can_load &&
                     (((state_reg == S_STEP0) && found0_reg) ||
                      ((state_reg == S_STEP1) && found1_reg));
    assign out_load = ((state_reg == S_ADD) && can_load) || step_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int s = 0; s < SLOTS; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
            it_ctx_reg <= 1'b0;
            it_value_reg <= '0;
            it_pri_reg <= '0;
            it_steps_reg <= '0;
            scan_ctx_reg <= 1'b0;
            scan_idx_reg <= '0;
            best_found_reg <= 1'b0;
            best_idx_reg <= '0;
            best_key_reg <= '0;
            found0_reg <= 1'b0;
            slot0_reg <= '0;
            found1_reg <= 1'b0;
            slot1_reg <= '0;
            out_valid_reg <= 1'b0;
            kind_reg <= tpts_pkg::KIND_STEP;
            ctx_out_reg <= 1'b0;
            value_out_reg <= '0;
            pri_out_reg <= '0;
            stepn_out_reg <= '0;
            total_out_reg <= '0;
            fin_out_reg <= 1'b0;
            square_out_reg <= '0;
            last_out_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_go)
                    begin
                        it_ctx_reg <= context_req;
                        it_value_reg <= task_value;
                        it_pri_reg <= task_priority;
                        it_steps_reg <= (task_steps == 8'd0) ? 8'd1 : task_steps;
                        scan_ctx_reg <= 1'b0;
                        scan_idx_reg <= '0;
                        best_found_reg <= 1'b0;
                        state_reg <= (mode == tpts_pkg::MODE_TICK) ? S_SCAN : S_ADD;
                    end
                end
                S_ADD:
                begin
                    if (can_load)
                    begin
                        out_valid_reg <= 1'b1;
                        kind_reg <= free_found ? tpts_pkg::KIND_ACCEPT : tpts_pkg::KIND_REJECT;
                        ctx_out_reg <= it_ctx_reg;
                        value_out_reg <= it_value_reg;
                        pri_out_reg <= it_pri_reg;
                        stepn_out_reg <= '0;
                        total_out_reg <= it_steps_reg;
                        fin_out_reg <= 1'b0;
                        square_out_reg <= '0;
                        last_out_reg <= 1'b1;
                        if (free_found)
                        begin
                            valid_reg[free_slot] <= 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_SCAN:
                begin
                    if (scan_idx_reg == tpts_pkg::LAST_IDX)
                    begin
                        best_found_reg <= 1'b0;
                        scan_idx_reg <= '0;
                        scan_ctx_reg <= 1'b1;
                        if (scan_ctx_reg)
                        begin
                            found1_reg <= nb_found;
                            slot1_reg <= nb_idx;
                            state_reg <= S_STEP0;
                        end
                        else
                        begin
                            found0_reg <= nb_found;
                            slot0_reg <= nb_idx;
                        end
                    end
                    else
                    begin
                        best_found_reg <= nb_found;
                        best_idx_reg <= nb_idx;
                        best_key_reg <= nb_key;
                        scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                    end
                end
                S_STEP0, S_STEP1:
                begin
                    if (step_go)
                    begin
                        out_valid_reg <= 1'b1;
                        kind_reg <= tpts_pkg::KIND_STEP;
                        ctx_out_reg <= (state_reg == S_STEP1);
                        value_out_reg <= value_reg[rd_slot];
                        pri_out_reg <= pri_reg[rd_slot];
                        stepn_out_reg <= done_next;
                        total_out_reg <= total_reg[rd_slot];
                        fin_out_reg <= fin_next;
                        square_out_reg <= fin_next ? square_next : '0;
                        last_out_reg <= (state_reg == S_STEP1) || !found1_reg;
                        if (fin_next)
                        begin
                            valid_reg[rd_slot] <= 1'b0;
                        end
                    end
                    if (step_go || ((state_reg == S_STEP0) && !found0_reg) ||
                        ((state_reg == S_STEP1) && !found1_reg))
                    begin
                        state_reg <= (state_reg == S_STEP0) ? S_STEP1 : S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (add_go)
        begin
            for (int i = 0; i < TASKS; i++)
            begin
                if (valid_reg[tpts_pkg::slot_of(it_ctx_reg, IDX_W'(i))] &&
                    (age_reg[tpts_pkg::slot_of(it_ctx_reg, IDX_W'(i))] != tpts_pkg::AGE_MAX))
                begin
                    age_reg[tpts_pkg::slot_of(it_ctx_reg, IDX_W'(i))] <=
                        age_reg[tpts_pkg::slot_of(it_ctx_reg, IDX_W'(i))] + 8'd1;
                end
            end
            value_reg[free_slot] <= it_value_reg;
            pri_reg[free_slot] <= it_pri_reg;
            total_reg[free_slot] <= it_steps_reg;
            done_reg[free_slot] <= '0;
            age_reg[free_slot] <= '0;
        end
        if (step_go)
        begin
            done_reg[rd_slot] <= done_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind = kind_reg;
    assign which_context = ctx_out_reg;
    assign out_value = value_out_reg;
    assign out_priority = pri_out_reg;
    assign step_number = stepn_out_reg;
    assign total_steps = total_out_reg;
    assign finished = fin_out_reg;
    assign square = square_out_reg;
    assign last = last_out_reg;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 60;
    localparam int TOTAL_WORDS = 1650;

    typedef struct {
        logic        mode;
        logic        ctx;
        logic [15:0] value;
        logic [7:0]  pri;
        logic [7:0]  steps;
        bit          hold;
    } task_word_t;

    typedef struct {
        tpts_pkg::kind_t kind;
        logic        ctx;
        logic [15:0] value;
        logic [7:0]  pri;
        logic [7:0]  step_no;
        logic [7:0]  total;
        logic        fin;
        logic [31:0] square;
        logic        last;
    } sched_report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        mode = 1'b0;
    logic        context_req = 1'b0;
    logic [15:0] task_value = 16'd0;
    logic [7:0]  task_priority = 8'd0;
    logic [7:0]  task_steps = 8'd0;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [1:0]  kind;
    logic        which_context;
    logic [15:0] out_value;
    logic [7:0]  out_priority;
    logic [7:0]  step_number;
    logic [7:0]  total_steps;
    logic        finished;
    logic [31:0] square;
    logic        last;

    bit          slot_live [tpts_pkg::SLOTS];
    logic [15:0] slot_value [tpts_pkg::SLOTS];
    logic [7:0]  slot_pri [tpts_pkg::SLOTS];
    logic [7:0]  slot_total [tpts_pkg::SLOTS];
    logic [7:0]  slot_done [tpts_pkg::SLOTS];
    logic [7:0]  slot_age [tpts_pkg::SLOTS];

    task_word_t    word_queue [$];
    sched_report_t report_queue [$];
    task_word_t    next_word;

    int words_made = 0;
    int words_in = 0;
    int words_seen = 0;
    int errors = 0;
    int quiet = 0;
    int gap_left = 0;
    int stall_left = 0;
    int calm_left = 0;
    bit calm = 1'b0;

    two_context_priority_task_scheduler i_dut (.*);

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic int choose_slot(input int c);
        int best;
        int s;
        best = -1;
        for (int i = 0; i < tpts_pkg::TASKS_PER_CONTEXT; i++)
        begin
            s = c * tpts_pkg::TASKS_PER_CONTEXT + i;
            if (slot_live[s])
            begin
                if (best < 0 || slot_pri[s] > slot_pri[best] ||
                    (slot_pri[s] == slot_pri[best] && slot_age[s] > slot_age[best]))
                    best = s;
            end
        end
        return best;
    endfunction

    task automatic predict_word(input task_word_t w);
        sched_report_t r;
        int            picked [2];
        int            base;
        int            free_slot;
        int            s;
        logic [7:0]    steps;
        if (w.mode == tpts_pkg::MODE_ADD)
        begin
            base = int'(w.ctx) * tpts_pkg::TASKS_PER_CONTEXT;
            steps = (w.steps == 8'd0) ? 8'd1 : w.steps;
            free_slot = -1;
            for (int i = 0; i < tpts_pkg::TASKS_PER_CONTEXT; i++)
                if (free_slot < 0 && !slot_live[base + i])
                    free_slot = base + i;
            r = '{tpts_pkg::KIND_REJECT, w.ctx, w.value, w.pri, 8'd0, steps,
                  1'b0, 32'd0, 1'b1};
            if (free_slot >= 0)
            begin
                r.kind = tpts_pkg::KIND_ACCEPT;
                for (int i = 0; i < tpts_pkg::TASKS_PER_CONTEXT; i++)
                    if (slot_live[base + i] && slot_age[base + i] != tpts_pkg::AGE_MAX)
                        slot_age[base + i] = slot_age[base + i] + 8'd1;
                slot_live[free_slot] = 1'b1;
                slot_value[free_slot] = w.value;
                slot_pri[free_slot] = w.pri;
                slot_total[free_slot] = steps;
                slot_done[free_slot] = 8'd0;
                slot_age[free_slot] = 8'd0;
            end
            report_queue = {report_queue, r};
        end
        else
        begin
            picked[0] = choose_slot(0);
            picked[1] = choose_slot(1);
            for (int c = 0; c < 2; c++)
            begin
                if (picked[c] >= 0)
                begin
                    s = picked[c];
                    slot_done[s] = slot_done[s] + 8'd1;
                    r.kind = tpts_pkg::KIND_STEP;
                    r.ctx = c[0];
                    r.value = slot_value[s];
                    r.pri = slot_pri[s];
                    r.step_no = slot_done[s];
                    r.total = slot_total[s];
                    r.fin = (slot_done[s] >= slot_total[s]);
                    r.square = r.fin ? {16'd0, slot_value[s]} * {16'd0, slot_value[s]} : 32'd0;
                    r.last = (c == 1) || (picked[1] < 0);
                    if (r.fin)
                        slot_live[s] = 1'b0;
                    report_queue = {report_queue, r};
                end
            end
        end
    endtask

    task automatic flag_mismatch(input string msg);
        errors++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s is %0h, wanted %0h", name, got, want));
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] rand_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    function automatic logic [7:0] rand_pri();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 8'd0;
        if (r == 1)
            return 8'd255;
        if (r < 5)
            return 8'($urandom_range(6, 8));
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] rand_steps();
        int r;
        r = $urandom_range(0, 19);
        if (r < 15)
            return 8'($urandom_range(1, 4));
        if (r == 15)
            return 8'd0;
        if (r == 16)
            return 8'd255;
        return 8'($urandom);
    endfunction

    task automatic queue_word(input logic m, input logic ctx, input logic [15:0] value,
                              input logic [7:0] pri, input logic [7:0] steps, input bit hold);
        task_word_t w;
        w = '{m, ctx, value, pri, steps, hold};
        word_queue = {word_queue, w};
        words_made++;
    endtask

    always @(posedge clk)
    begin
        task_word_t    seen;
        sched_report_t want;
        if (rst_n)
        begin
            quiet = quiet + 1;
            if (in_valid && in_ready)
            begin
                seen = '{mode, context_req, task_value, task_priority, task_steps, 1'b0};
                predict_word(seen);
                words_in++;
                quiet = 0;
            end
            if (out_valid && out_ready)
            begin
                quiet = 0;
                if (report_queue.size() == 0)
                    flag_mismatch("report word with none expected");
                else
                begin
                    want = report_queue.pop_front();
                    check_field("kind", kind, want.kind);
                    check_field("which_context", which_context, want.ctx);
                    check_field("out_value", out_value, want.value);
                    check_field("out_priority", out_priority, want.pri);
                    check_field("step_number", step_number, want.step_no);
                    check_field("total_steps", total_steps, want.total);
                    check_field("finished", finished, want.fin);
                    check_field("square", square, want.square);
                    check_field("last", last, want.last);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        bit drive_valid;
        if (rst_n)
        begin
            if (calm_left == 0)
            begin
                calm_left = $urandom_range(50, 300);
                calm = ($urandom_range(0, 3) == 0);
            end
            else
                calm_left--;
            drive_valid = in_valid;
            if (in_valid && words_in != words_seen)
            begin
                words_seen++;
                drive_valid = 1'b0;
            end
            if (!drive_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (word_queue.size() > 0 &&
                         !(word_queue[0].hold && report_queue.size() != 0))
                begin
                    next_word = word_queue.pop_front();
                    drive_valid = 1'b1;
                    gap_left = pick_gap();
                end
            end
            in_valid <= drive_valid;
            mode <= next_word.mode;
            context_req <= next_word.ctx;
            task_value <= next_word.value;
            task_priority <= next_word.pri;
            task_steps <= next_word.steps;
            if (stall_left > 0)
                stall_left--;
            else
                stall_left = pick_gap();
            out_ready <= (stall_left == 0);
        end
    end

    initial
    begin
        int phase;
        int len;
        bit focus;
        bit hold;
        bit is_tick;
        next_word = '{tpts_pkg::MODE_TICK, 1'b0, 16'd0, 8'd0, 8'd0, 1'b0};

        queue_word(tpts_pkg::MODE_TICK, 1'b1, 16'hFFFF, 8'hFF, 8'hFF, 1'b0);
        queue_word(tpts_pkg::MODE_ADD, 1'b0, 16'h0000, 8'h00, 8'h00, 1'b0);
        queue_word(tpts_pkg::MODE_ADD, 1'b0, 16'hFFFF, 8'h10, 8'hFF, 1'b0);
        queue_word(tpts_pkg::MODE_TICK, 1'b0, 16'h0000, 8'h00, 8'h00, 1'b0);
        queue_word(tpts_pkg::MODE_ADD, 1'b1, 16'hFFFF, 8'hFF, 8'h01, 1'b0);
        queue_word(tpts_pkg::MODE_ADD, 1'b1, 16'h8001, 8'hFF, 8'h02, 1'b0);
        queue_word(tpts_pkg::MODE_ADD, 1'b1, 16'h0001, 8'h00, 8'h03, 1'b0);
        queue_word(tpts_pkg::MODE_TICK, 1'b0, 16'h5555, 8'h55, 8'h55, 1'b0);
        queue_word(tpts_pkg::MODE_ADD, 1'b1, 16'h5555, 8'h80, 8'h01, 1'b0);
        queue_word(tpts_pkg::MODE_ADD, 1'b1, 16'hAAAA, 8'h80, 8'h80, 1'b0);
        queue_word(tpts_pkg::MODE_ADD, 1'b1, 16'h8000, 8'h7F, 8'hFE, 1'b0);
        queue_word(tpts_pkg::MODE_ADD, 1'b1, 16'h00FF, 8'h01, 8'h7F, 1'b0);
        queue_word(tpts_pkg::MODE_ADD, 1'b1, 16'hFF00, 8'hAA, 8'h01, 1'b0);
        queue_word(tpts_pkg::MODE_ADD, 1'b1, 16'h1234, 8'h55, 8'h02, 1'b0);
        queue_word(tpts_pkg::MODE_ADD, 1'b1, 16'hFFFF, 8'hFF, 8'hFF, 1'b0);
        queue_word(tpts_pkg::MODE_ADD, 1'b0, 16'h0F0F, 8'h10, 8'h01, 1'b0);
        queue_word(tpts_pkg::MODE_ADD, 1'b0, 16'hF0F0, 8'hFF, 8'h02, 1'b0);
        queue_word(tpts_pkg::MODE_ADD, 1'b0, 16'h3C3C, 8'hFF, 8'h01, 1'b0);
        queue_word(tpts_pkg::MODE_ADD, 1'b0, 16'hC3C3, 8'h00, 8'h00, 1'b0);
        queue_word(tpts_pkg::MODE_ADD, 1'b0, 16'h7FFF, 8'h80, 8'h03, 1'b0);
        queue_word(tpts_pkg::MODE_ADD, 1'b0, 16'h0002, 8'h40, 8'h01, 1'b0);
        queue_word(tpts_pkg::MODE_ADD, 1'b0, 16'h0003, 8'h20, 8'h01, 1'b0);
        queue_word(tpts_pkg::MODE_TICK, 1'b1, 16'hAAAA, 8'hAA, 8'hAA, 1'b1);
        queue_word(tpts_pkg::MODE_TICK, 1'b0, 16'h0000, 8'h00, 8'h00, 1'b0);
        queue_word(tpts_pkg::MODE_TICK, 1'b1, 16'hFFFF, 8'hFF, 8'hFF, 1'b0);

        while (words_made < TOTAL_WORDS)
        begin
            phase = $urandom_range(0, 2);
            len = $urandom_range(4, 24);
            focus = $urandom_range(0, 1);
            for (int k = 0; k < len; k++)
            begin
                hold = ($urandom_range(0, 199) == 0);
                case (phase)
                    0: is_tick = ($urandom_range(0, 4) == 0);
                    1: is_tick = ($urandom_range(0, 4) != 0);
                    default: is_tick = $urandom_range(0, 1);
                endcase
                if (is_tick)
                    queue_word(tpts_pkg::MODE_TICK, 1'($urandom), 16'($urandom),
                               8'($urandom), 8'($urandom), hold);
                else
                    queue_word(tpts_pkg::MODE_ADD, ($urandom_range(0, 3) == 0) ? !focus : focus,
                               rand_value(), rand_pri(), rand_steps(), hold);
            end
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (!(words_in == words_made && report_queue.size() == 0) && quiet < QUIET_LIMIT)
            @(negedge clk);
        if (quiet >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            repeat (SETTLE_CYCLES) @(negedge clk);
            if (errors == 0 && report_queue.size() == 0)
                $display("All tests passed");
            else
                $display("Some tests failed");
            $finish;
        end
    end

endmodule
